// ===== rtl/pfke_pkg.sv =====
// Package for the flow key extractor: widths, header codes and the result type.
`default_nettype none

package pfke_pkg;

  localparam int unsigned OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  localparam pos_t POS_MAX    = '1;
  localparam pos_t ETH_HDR_LEN = pos_t'(14);

  localparam logic [15:0] ETHERTYPE_QINQ = 16'h88A8;
  localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

  localparam logic [15:0] IPV4_FLAG_MF       = 16'h2000;
  localparam logic [15:0] IPV4_FRAG_OFF_MASK = 16'h1FFF;
  localparam logic [3:0]  IPV4_IHL_MIN       = 4'd5;
  localparam logic [7:0]  IPV4_IHL_MASK      = 8'h0F;
  localparam pos_t        IPV6_HDR_LEN       = pos_t'(40);
  localparam pos_t        AH_PORT_SKIP       = pos_t'(4);

  localparam logic [7:0] PROTO_IPIP    = 8'd4;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PROTO_DCCP    = 8'd33;
  localparam logic [7:0] PROTO_IPV6    = 8'd41;
  localparam logic [7:0] PROTO_GRE     = 8'd47;
  localparam logic [7:0] PROTO_ESP     = 8'd50;
  localparam logic [7:0] PROTO_AH      = 8'd51;
  localparam logic [7:0] PROTO_SCTP    = 8'd132;
  localparam logic [7:0] PROTO_UDPLITE = 8'd136;

  typedef enum logic [1:0] {
    STATUS_PARSED    = 2'd0,
    STATUS_NOT_IP    = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    pos_t        transport_offset;
    logic [7:0]  l4_proto;
    logic [31:0] ports;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
  } flow_key_t;

endpackage

`default_nettype wire

// ===== rtl/pfke_parser.sv =====
// Byte-wide header parser that builds one flow key per frame.
`default_nettype none

module pfke_parser import pfke_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       beat_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output logic            key_valid_o,
  output flow_key_t       key_o
);

  typedef enum logic [2:0] {
    ST_ETH, ST_VLAN_AD, ST_VLAN_Q, ST_IP4, ST_IP6, ST_PORTS, ST_DONE, ST_NOTIP
  } stage_e;

  stage_e      stage_q, stage_d;
  pos_t        pos_q, pos_d;
  pos_t        base_q, base_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0]  vihl_q, vihl_d;
  logic        frag_q, frag_d;
  logic        tunnel_q, tunnel_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [31:0] ports_q, ports_d;
  pos_t        poff_q, poff_d;

  pos_t        rel_hdr;
  pos_t        rel_port;
  logic [15:0] etype_sh;
  logic [3:0]  ihl;
  logic [31:0] lane;
  logic        an_go;
  pos_t        an_next;
  logic [7:0]  an_proto;
  logic [7:0]  p4;

  assign rel_hdr  = pos_q - base_q;
  assign rel_port = pos_q - poff_q;
  assign etype_sh = {etype_q[7:0], data_i};
  assign ihl      = ((vihl_q & IPV4_IHL_MASK) < {4'd0, IPV4_IHL_MIN}) ? IPV4_IHL_MIN
                                                                     : vihl_q[3:0];
  assign lane     = {data_i, 24'd0} >> {rel_hdr[1:0], 3'b000};
  assign p4       = frag_q ? 8'd0 : data_i;

  always_comb begin
    stage_d  = stage_q;
    base_d   = base_q;
    etype_d  = etype_q;
    vihl_d   = vihl_q;
    frag_d   = frag_q;
    tunnel_d = tunnel_q;
    proto_d  = proto_q;
    src_d    = src_q;
    dst_d    = dst_q;
    ports_d  = ports_q;
    poff_d   = poff_q;
    an_go    = 1'b0;
    an_next  = base_q + pos_t'({ihl, 2'b00});
    an_proto = proto_q;

    case (stage_q)
      ST_ETH: begin
        if (pos_q == pos_t'(12) || pos_q == pos_t'(13)) begin
          etype_d = etype_sh;
        end
        if (pos_q == pos_t'(13)) begin
          if (etype_sh == ETHERTYPE_QINQ) begin
            stage_d = ST_VLAN_AD;
          end else if (etype_sh == ETHERTYPE_VLAN) begin
            stage_d = ST_VLAN_Q;
          end else if (etype_sh == ETHERTYPE_IPV4) begin
            stage_d = ST_IP4;
          end else if (etype_sh == ETHERTYPE_IPV6) begin
            stage_d = ST_IP6;
          end else begin
            stage_d = ST_NOTIP;
          end
        end
      end
      ST_VLAN_AD, ST_VLAN_Q: begin
        if (rel_hdr == pos_t'(2) || rel_hdr == pos_t'(3)) begin
          etype_d = etype_sh;
        end
        if (rel_hdr == pos_t'(3)) begin
          base_d = base_q + pos_t'(4);
          if (stage_q == ST_VLAN_AD && etype_sh == ETHERTYPE_VLAN) begin
            stage_d = ST_VLAN_Q;
          end else if (etype_sh == ETHERTYPE_IPV4) begin
            stage_d = ST_IP4;
          end else if (etype_sh == ETHERTYPE_IPV6) begin
            stage_d = ST_IP6;
          end else begin
            stage_d = ST_NOTIP;
          end
        end
      end
      ST_IP4: begin
        if (rel_hdr == pos_t'(0)) begin
          vihl_d = data_i;
        end else if (rel_hdr == pos_t'(6)) begin
          frag_d = (({data_i, 8'h00} & (IPV4_FLAG_MF | IPV4_FRAG_OFF_MASK)) != 16'd0);
        end else if (rel_hdr == pos_t'(7)) begin
          if (({8'h00, data_i} & IPV4_FRAG_OFF_MASK) != 16'd0) begin
            frag_d = 1'b1;
          end
        end else if (rel_hdr == pos_t'(9)) begin
          proto_d  = p4;
          an_proto = p4;
          an_go    = (p4 == PROTO_GRE);
        end else if (rel_hdr >= pos_t'(12) && rel_hdr <= pos_t'(15)) begin
          src_d = {src_q[23:0], data_i};
        end else if (rel_hdr >= pos_t'(16) && rel_hdr <= pos_t'(19)) begin
          dst_d = {dst_q[23:0], data_i};
          an_go = (rel_hdr == pos_t'(19));
        end
      end
      ST_IP6: begin
        an_next = base_q + IPV6_HDR_LEN;
        if (rel_hdr == pos_t'(6)) begin
          proto_d = data_i;
        end else if (rel_hdr >= pos_t'(8) && rel_hdr <= pos_t'(23)) begin
          src_d = ((rel_hdr == pos_t'(8)) ? 32'd0 : src_q) ^ lane;
        end else if (rel_hdr >= pos_t'(24) && rel_hdr <= pos_t'(39)) begin
          dst_d = ((rel_hdr == pos_t'(24)) ? 32'd0 : dst_q) ^ lane;
          an_go = (rel_hdr == pos_t'(39));
        end
      end
      ST_PORTS: begin
        if (rel_port <= pos_t'(3)) begin
          ports_d = {ports_q[23:0], data_i};
        end
        if (rel_port == pos_t'(3)) begin
          stage_d = ST_DONE;
        end
      end
      default: begin
      end
    endcase

    if (an_go) begin
      if (!tunnel_q && (an_proto == PROTO_IPIP || an_proto == PROTO_IPV6)) begin
        tunnel_d = 1'b1;
        base_d   = an_next;
        stage_d  = (an_proto == PROTO_IPIP) ? ST_IP4 : ST_IP6;
      end else begin
        case (an_proto)
          PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_ESP, PROTO_SCTP, PROTO_UDPLITE: begin
            poff_d  = an_next;
            stage_d = ST_PORTS;
          end
          PROTO_AH: begin
            poff_d  = an_next + AH_PORT_SKIP;
            stage_d = ST_PORTS;
          end
          default: begin
            poff_d  = an_next;
            stage_d = ST_DONE;
          end
        endcase
      end
    end

    pos_d = (pos_q < POS_MAX) ? pos_q + pos_t'(1) : pos_q;
  end

  always_comb begin
    key_valid_o = beat_i && last_i;
    key_o       = '0;
    if (stage_d == ST_DONE) begin
      key_o.src_ip           = src_d;
      key_o.dst_ip           = dst_d;
      key_o.ports            = ports_d;
      key_o.l4_proto         = proto_d;
      key_o.transport_offset = poff_d;
      key_o.status           = STATUS_PARSED;
    end else if (stage_d == ST_NOTIP) begin
      key_o.status = STATUS_NOT_IP;
    end else begin
      key_o.status = STATUS_TRUNCATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ST_ETH;
      pos_q    <= '0;
      base_q   <= ETH_HDR_LEN;
      etype_q  <= '0;
      vihl_q   <= '0;
      frag_q   <= 1'b0;
      tunnel_q <= 1'b0;
      proto_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      ports_q  <= '0;
      poff_q   <= '0;
    end else if (beat_i && last_i) begin
      stage_q  <= ST_ETH;
      pos_q    <= '0;
      base_q   <= ETH_HDR_LEN;
      etype_q  <= '0;
      vihl_q   <= '0;
      frag_q   <= 1'b0;
      tunnel_q <= 1'b0;
      proto_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      ports_q  <= '0;
      poff_q   <= '0;
    end else if (beat_i) begin
      stage_q  <= stage_d;
      pos_q    <= pos_d;
      base_q   <= base_d;
      etype_q  <= etype_d;
      vihl_q   <= vihl_d;
      frag_q   <= frag_d;
      tunnel_q <= tunnel_d;
      proto_q  <= proto_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      ports_q  <= ports_d;
      poff_q   <= poff_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/packet_flow_key_extractor.sv =====
// Flow key extractor top level: frame byte stream in, one flow key beat per frame out.
//
// The slave channel takes one frame byte per beat in wire order, starting at the
// destination MAC, with tlast on the final byte. Each byte is parsed in the cycle it
// is accepted, so the input runs at one beat per cycle while tready is high. On the
// tlast beat a flow key is built and registered, in the skid register if the receiver
// stalls, and is offered on the master channel from the result register. tuser carries
// the parse status, and when the status is not "parsed" all tdata fields are zero.
// The output has a result register and a one-entry skid register. If the receiver
// stalls, the input keeps taking bytes; a second finished key waits in the skid
// register, and only while that register is full does tready on the input drop.
// Reset clears the parser state and empties both registers.
`default_nettype none

module packet_flow_key_extractor import pfke_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // data_byte
  input  wire logic         s_axis_tlast_i,   // last_byte
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // src_ip[31:0], dst_ip[63:32], ports[95:64], l4_proto[103:96],
  // transport_offset[119:104]
  output logic [119:0]      m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o    // status
);

  logic      in_beat;
  logic      key_valid;
  flow_key_t key;
  logic      out_valid_q;
  logic      skid_valid_q;
  flow_key_t out_q;
  flow_key_t skid_q;
  logic      out_free;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  pfke_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (in_beat),
    .data_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .key_valid_o (key_valid),
    .key_o       (key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= key_valid;
      end
    end else if (key_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (key_valid) begin
        out_q <= key;
      end
    end else if (key_valid) begin
      skid_q <= key;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.transport_offset, out_q.l4_proto, out_q.ports,
                            out_q.dst_ip, out_q.src_ip};
  assign m_axis_tuser_o  = out_q.status;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds a key while the output register is empty.");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_valid && out_valid_q && !m_axis_tready_i) |=> skid_valid_q)
    else $error("A key finished during a stall was not held in the skid register.");

  a_failed_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tuser_o != STATUS_PARSED) |-> (m_axis_tdata_o == '0))
    else $error("A key with a failure status carries nonzero fields.");
`endif

endmodule

`default_nettype wire
